@@ src/slx_pkg.sv @@
// Shared types, codes and character classes for the SQL token lexer.
package slx_pkg;

    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_IDENT  = 3'd1;
    localparam logic [2:0] MODE_NUMBER = 3'd2;
    localparam logic [2:0] MODE_MINUS  = 3'd3;
    localparam logic [2:0] MODE_STRING = 3'd4;
    localparam logic [2:0] MODE_QUOTE  = 3'd5;
    localparam logic [2:0] MODE_ERROR  = 3'd6;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_TOKEN = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [3:0] TOK_IDENT  = 4'd0;
    localparam logic [3:0] TOK_NUMBER = 4'd1;
    localparam logic [3:0] TOK_STRING = 4'd2;
    localparam logic [3:0] TOK_COMMA  = 4'd3;
    localparam logic [3:0] TOK_DOT    = 4'd4;
    localparam logic [3:0] TOK_LPAREN = 4'd5;
    localparam logic [3:0] TOK_RPAREN = 4'd6;
    localparam logic [3:0] TOK_STAR   = 4'd7;
    localparam logic [3:0] TOK_EOF    = 4'd8;

    localparam logic [1:0] ERR_UNEXPECTED   = 2'd0;
    localparam logic [1:0] ERR_NEWLINE      = 2'd1;
    localparam logic [1:0] ERR_UNTERMINATED = 2'd2;

    localparam logic [7:0] CH_QUOTE      = 8'h27;
    localparam logic [7:0] CH_MINUS      = 8'h2d;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
    localparam logic [7:0] CH_COMMA      = 8'h2c;
    localparam logic [7:0] CH_DOT        = 8'h2e;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2a;
    localparam logic [7:0] CH_NEWLINE    = 8'h0a;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] token_type;
        logic [7:0] char_value;
        logic [1:0] error_code;
        logic       last;
    } res_ctl_t;

    localparam int RES_CTL_W = $bits(res_ctl_t);

    function automatic logic is_alpha(input logic [7:0] b);
        return (b inside {[8'h41:8'h5a], [8'h61:8'h7a]});
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b inside {8'h20, [8'h09:8'h0d]});
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return (b inside {CH_COMMA, CH_DOT, CH_LPAREN, CH_RPAREN, CH_STAR});
    endfunction

    function automatic logic [3:0] punct_type(input logic [7:0] b);
        logic [3:0] t;
        case (b)
            CH_COMMA:  t = TOK_COMMA;
            CH_DOT:    t = TOK_DOT;
            CH_LPAREN: t = TOK_LPAREN;
            CH_RPAREN: t = TOK_RPAREN;
            default:   t = TOK_STAR;
        endcase
        return t;
    endfunction

endpackage

@@ src/slx_lexer_core.sv @@
// Lexer state registers and the combinational step that forms up to three results per beat.
module slx_lexer_core
    import slx_pkg::*;
#(
    parameter int POS_WIDTH = 24,
    parameter int LEN_WIDTH = 16,
    localparam int RES_W = RES_CTL_W + 2 * POS_WIDTH + LEN_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic [1:0]           cmd,
    input  logic [7:0]           byte_value,
    input  logic [POS_WIDTH-1:0] origin_line,
    input  logic [POS_WIDTH-1:0] origin_column,
    output logic [1:0]           res_count,
    output logic [RES_W-1:0]     res_data [MAX_RESULTS]
);

    typedef struct packed {
        res_ctl_t             ctl;
        logic [POS_WIDTH-1:0] line;
        logic [POS_WIDTH-1:0] column;
        logic [LEN_WIDTH-1:0] len;
    } res_t;

    logic [2:0]           mode_reg, mode_next;
    logic [POS_WIDTH-1:0] cur_line_reg, cur_line_next;
    logic [POS_WIDTH-1:0] cur_col_reg, cur_col_next;
    logic [POS_WIDTH-1:0] st_line_reg, st_line_next;
    logic [POS_WIDTH-1:0] st_col_reg, st_col_next;
    logic [LEN_WIDTH-1:0] len_reg, len_next;
    res_t                 res [MAX_RESULTS];
    logic [1:0]           n;

    function automatic logic [POS_WIDTH-1:0] inc_pos(input logic [POS_WIDTH-1:0] v);
        return (v == '1) ? v : v + POS_WIDTH'(1);
    endfunction

    function automatic logic [LEN_WIDTH-1:0] inc_len(input logic [LEN_WIDTH-1:0] v);
        return (v == '1) ? v : v + LEN_WIDTH'(1);
    endfunction

    function automatic res_t mk(input logic [1:0] kind, input logic [3:0] ttype,
                                input logic [7:0] ch, input logic [POS_WIDTH-1:0] ln,
                                input logic [POS_WIDTH-1:0] cl,
                                input logic [LEN_WIDTH-1:0] len,
                                input logic [1:0] err);
        res_t r;
        r.ctl.kind       = kind;
        r.ctl.token_type = ttype;
        r.ctl.char_value = ch;
        r.ctl.error_code = err;
        r.ctl.last       = 1'b0;
        r.line           = ln;
        r.column         = cl;
        r.len            = len;
        return r;
    endfunction

    always_comb
    begin
        logic       do_idle;
        logic       more;
        logic [3:0] ttype;
        logic [7:0] b;

        b             = byte_value;
        do_idle       = 1'b0;
        more          = 1'b0;
        ttype         = TOK_IDENT;
        n             = 2'd0;
        mode_next     = mode_reg;
        cur_line_next = cur_line_reg;
        cur_col_next  = cur_col_reg;
        st_line_next  = st_line_reg;
        st_col_next   = st_col_reg;
        len_next      = len_reg;
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            res[k] = '0;
        end

        case (cmd)
            CMD_BYTE:
            begin
                case (mode_reg)
                    MODE_IDENT, MODE_NUMBER:
                    begin
                        ttype = (mode_reg == MODE_IDENT) ? TOK_IDENT : TOK_NUMBER;
                        more  = (mode_reg == MODE_IDENT) ?
                                (is_alpha(b) || is_digit(b) || b == CH_UNDERSCORE) :
                                is_digit(b);
                        if (more)
                        begin
                            len_next = inc_len(len_reg);
                            res[n] = mk(KIND_CHAR, ttype, b, st_line_reg, st_col_reg,
                                        len_next, ERR_UNEXPECTED);
                            n = n + 2'd1;
                            cur_col_next = inc_pos(cur_col_reg);
                        end
                        else
                        begin
                            res[n] = mk(KIND_TOKEN, ttype, 8'h00, st_line_reg, st_col_reg,
                                        len_reg, ERR_UNEXPECTED);
                            n = n + 2'd1;
                            mode_next = MODE_IDLE;
                            do_idle = 1'b1;
                        end
                    end
                    MODE_MINUS:
                    begin
                        if (is_digit(b))
                        begin
                            res[n] = mk(KIND_CHAR, TOK_NUMBER, CH_MINUS, st_line_reg,
                                        st_col_reg, LEN_WIDTH'(1), ERR_UNEXPECTED);
                            n = n + 2'd1;
                            len_next = LEN_WIDTH'(2);
                            res[n] = mk(KIND_CHAR, TOK_NUMBER, b, st_line_reg, st_col_reg,
                                        len_next, ERR_UNEXPECTED);
                            n = n + 2'd1;
                            mode_next = MODE_NUMBER;
                            cur_col_next = inc_pos(cur_col_reg);
                        end
                        else
                        begin
                            res[n] = mk(KIND_ERROR, TOK_IDENT, CH_MINUS, st_line_reg,
                                        st_col_reg, '0, ERR_UNEXPECTED);
                            n = n + 2'd1;
                            mode_next = MODE_ERROR;
                        end
                    end
                    MODE_STRING:
                    begin
                        if (b == CH_NEWLINE)
                        begin
                            res[n] = mk(KIND_ERROR, TOK_IDENT, b, st_line_reg, st_col_reg,
                                        '0, ERR_NEWLINE);
                            n = n + 2'd1;
                            mode_next = MODE_ERROR;
                        end
                        else if (b == CH_QUOTE)
                        begin
                            mode_next = MODE_QUOTE;
                            cur_col_next = inc_pos(cur_col_reg);
                        end
                        else
                        begin
                            len_next = inc_len(len_reg);
                            res[n] = mk(KIND_CHAR, TOK_STRING, b, st_line_reg, st_col_reg,
                                        len_next, ERR_UNEXPECTED);
                            n = n + 2'd1;
                            cur_col_next = inc_pos(cur_col_reg);
                        end
                    end
                    MODE_QUOTE:
                    begin
                        if (b == CH_QUOTE)
                        begin
                            len_next = inc_len(len_reg);
                            res[n] = mk(KIND_CHAR, TOK_STRING, b, st_line_reg, st_col_reg,
                                        len_next, ERR_UNEXPECTED);
                            n = n + 2'd1;
                            mode_next = MODE_STRING;
                            cur_col_next = inc_pos(cur_col_reg);
                        end
                        else
                        begin
                            res[n] = mk(KIND_TOKEN, TOK_STRING, 8'h00, st_line_reg,
                                        st_col_reg, len_reg, ERR_UNEXPECTED);
                            n = n + 2'd1;
                            mode_next = MODE_IDLE;
                            do_idle = 1'b1;
                        end
                    end
                    MODE_ERROR:
                    begin
                        mode_next = MODE_ERROR;
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                        do_idle = 1'b1;
                    end
                endcase

                // Between tokens: whitespace, the start of a new token, or a bad byte.
                if (do_idle)
                begin
                    if (is_space(b))
                    begin
                        if (b == CH_NEWLINE)
                        begin
                            cur_line_next = inc_pos(cur_line_reg);
                            cur_col_next  = POS_WIDTH'(1);
                        end
                        else
                        begin
                            cur_col_next = inc_pos(cur_col_reg);
                        end
                    end
                    else if (is_alpha(b) || is_digit(b) || b == CH_UNDERSCORE ||
                             b == CH_MINUS || b == CH_QUOTE || is_punct(b))
                    begin
                        st_line_next = cur_line_reg;
                        st_col_next  = cur_col_reg;
                        cur_col_next = inc_pos(cur_col_reg);
                        len_next     = (b == CH_QUOTE) ? '0 : LEN_WIDTH'(1);
                        if (is_alpha(b) || b == CH_UNDERSCORE || is_digit(b))
                        begin
                            ttype = is_digit(b) ? TOK_NUMBER : TOK_IDENT;
                            mode_next = is_digit(b) ? MODE_NUMBER : MODE_IDENT;
                            res[n] = mk(KIND_CHAR, ttype, b, cur_line_reg, cur_col_reg,
                                        LEN_WIDTH'(1), ERR_UNEXPECTED);
                            n = n + 2'd1;
                        end
                        else if (b == CH_MINUS)
                        begin
                            mode_next = MODE_MINUS;
                        end
                        else if (b == CH_QUOTE)
                        begin
                            mode_next = MODE_STRING;
                        end
                        else
                        begin
                            ttype = punct_type(b);
                            mode_next = MODE_IDLE;
                            res[n] = mk(KIND_CHAR, ttype, b, cur_line_reg, cur_col_reg,
                                        LEN_WIDTH'(1), ERR_UNEXPECTED);
                            n = n + 2'd1;
                            res[n] = mk(KIND_TOKEN, ttype, 8'h00, cur_line_reg, cur_col_reg,
                                        LEN_WIDTH'(1), ERR_UNEXPECTED);
                            n = n + 2'd1;
                        end
                    end
                    else
                    begin
                        res[n] = mk(KIND_ERROR, TOK_IDENT, b, cur_line_reg, cur_col_reg,
                                    '0, ERR_UNEXPECTED);
                        n = n + 2'd1;
                        mode_next = MODE_ERROR;
                    end
                end
            end
            CMD_END:
            begin
                case (mode_reg)
                    MODE_IDENT, MODE_NUMBER, MODE_QUOTE:
                    begin
                        ttype = (mode_reg == MODE_IDENT)  ? TOK_IDENT :
                                (mode_reg == MODE_NUMBER) ? TOK_NUMBER : TOK_STRING;
                        res[n] = mk(KIND_TOKEN, ttype, 8'h00, st_line_reg, st_col_reg,
                                    len_reg, ERR_UNEXPECTED);
                        n = n + 2'd1;
                        res[n] = mk(KIND_TOKEN, TOK_EOF, 8'h00, cur_line_reg, cur_col_reg,
                                    '0, ERR_UNEXPECTED);
                        n = n + 2'd1;
                    end
                    MODE_MINUS:
                    begin
                        res[n] = mk(KIND_ERROR, TOK_IDENT, CH_MINUS, st_line_reg, st_col_reg,
                                    '0, ERR_UNEXPECTED);
                        n = n + 2'd1;
                    end
                    MODE_STRING:
                    begin
                        res[n] = mk(KIND_ERROR, TOK_IDENT, 8'h00, st_line_reg, st_col_reg,
                                    '0, ERR_UNTERMINATED);
                        n = n + 2'd1;
                    end
                    MODE_ERROR:
                    begin
                        n = 2'd0;
                    end
                    default:
                    begin
                        res[n] = mk(KIND_TOKEN, TOK_EOF, 8'h00, cur_line_reg, cur_col_reg,
                                    '0, ERR_UNEXPECTED);
                        n = n + 2'd1;
                    end
                endcase
                mode_next = MODE_IDLE;
            end
            CMD_START:
            begin
                mode_next     = MODE_IDLE;
                cur_line_next = origin_line;
                cur_col_next  = origin_column;
                st_line_next  = '0;
                st_col_next   = '0;
                len_next      = '0;
            end
            default:
            begin
                n = 2'd0;
            end
        endcase

        if (n != 2'd0)
        begin
            res[n - 2'd1].ctl.last = 1'b1;
        end
    end

    assign res_count = step_en ? n : 2'd0;

    always_comb
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            res_data[k] = res[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            cur_line_reg <= POS_WIDTH'(1);
            cur_col_reg  <= POS_WIDTH'(1);
            st_line_reg  <= '0;
            st_col_reg   <= '0;
            len_reg      <= '0;
        end
        else if (step_en)
        begin
            mode_reg     <= mode_next;
            cur_line_reg <= cur_line_next;
            cur_col_reg  <= cur_col_next;
            st_line_reg  <= st_line_next;
            st_col_reg   <= st_col_next;
            len_reg      <= len_next;
        end
    end

    // After an error, further text bytes produce nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && cmd == CMD_BYTE && mode_reg == MODE_ERROR) |-> res_count == 2'd0)
        else $error("byte after error produced a result");

    // Starting a new text lands in idle at the given position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && cmd == CMD_START) |=>
            (mode_reg == MODE_IDLE && cur_line_reg == $past(origin_line) &&
             cur_col_reg == $past(origin_column)))
        else $error("start of text did not load position");

endmodule

@@ src/slx_result_queue.sv @@
// Shift-register result queue that takes up to three results per cycle and releases one.
module slx_result_queue
    import slx_pkg::*;
#(
    parameter int W = 97
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_count,
    input  logic [W-1:0]     push_data [MAX_RESULTS],
    input  logic             pop,
    output logic [W-1:0]     head,
    output logic             valid,
    output logic [CNT_W-1:0] count
);

    logic [W-1:0]     slot_reg [QUEUE_DEPTH];
    logic [W-1:0]     slot_next [QUEUE_DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cnt_after_pop;

    assign cnt_after_pop = count_reg - CNT_W'(pop);
    assign count_next    = cnt_after_pop + CNT_W'(push_count);

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
        begin
            slot_next[i] = pop ? slot_reg[i + 1] : slot_reg[i];
        end
        slot_next[QUEUE_DEPTH - 1] = slot_reg[QUEUE_DEPTH - 1];
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            for (int j = 0; j < MAX_RESULTS; j++)
            begin
                if ((2'(j) < push_count) && (CNT_W'(i) == cnt_after_pop + CNT_W'(j)))
                begin
                    slot_next[i] = push_data[j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head  = slot_reg[0];
    assign valid = (count_reg != '0);
    assign count = count_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty result queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 && !pop) |=> count_reg == CNT_W'($past(push_count)))
        else $error("result queue count mismatch after push");

endmodule

@@ src/sql_token_lexer_unit.sv @@
// Top level of the streaming SQL token lexer.
// One command beat is taken per cycle while item_ready is high; every beat is decoded in
// the cycle it is taken and its zero to three results are registered in a four-entry
// result queue, from which one result beat leaves per cycle while result_ready is high.
// The command channel is ready whenever the queue holds at most one result, so a stream
// whose beats each cause at most one result runs at one beat per cycle while results are
// taken as they come; a beat that causes two or three results holds off the command channel
// while the queue drains. The last flag marks the final result of each command beat.
module sql_token_lexer_unit
    import slx_pkg::*;
#(
    parameter int POS_WIDTH = 24,
    parameter int LEN_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [1:0]           cmd,
    input  logic [7:0]           byte_value,
    input  logic [POS_WIDTH-1:0] origin_line,
    input  logic [POS_WIDTH-1:0] origin_column,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [1:0]           kind,
    output logic [3:0]           token_type,
    output logic [7:0]           char_value,
    output logic [POS_WIDTH-1:0] line,
    output logic [POS_WIDTH-1:0] column,
    output logic [LEN_WIDTH-1:0] token_length,
    output logic [1:0]           error_code,
    output logic                 last
);

    localparam int RES_W = RES_CTL_W + 2 * POS_WIDTH + LEN_WIDTH;

    logic             accept;
    logic             pop;
    logic [1:0]       res_count;
    logic [RES_W-1:0] res_data [MAX_RESULTS];
    logic [RES_W-1:0] head;
    logic [CNT_W-1:0] q_count;
    res_ctl_t         head_ctl;

    assign item_ready = (q_count <= CNT_W'(1));
    assign accept     = item_valid && item_ready;
    assign pop        = result_valid && result_ready;

    slx_lexer_core #(
        .POS_WIDTH (POS_WIDTH),
        .LEN_WIDTH (LEN_WIDTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (accept),
        .cmd           (cmd),
        .byte_value    (byte_value),
        .origin_line   (origin_line),
        .origin_column (origin_column),
        .res_count     (res_count),
        .res_data      (res_data)
    );

    slx_result_queue #(
        .W (RES_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (res_count),
        .push_data  (res_data),
        .pop        (pop),
        .head       (head),
        .valid      (result_valid),
        .count      (q_count)
    );

    assign head_ctl     = res_ctl_t'(head[RES_W-1 -: RES_CTL_W]);
    assign kind         = head_ctl.kind;
    assign token_type   = head_ctl.token_type;
    assign char_value   = head_ctl.char_value;
    assign error_code   = head_ctl.error_code;
    assign last         = head_ctl.last;
    assign line         = head[LEN_WIDTH + 2 * POS_WIDTH - 1 -: POS_WIDTH];
    assign column       = head[LEN_WIDTH + POS_WIDTH - 1 -: POS_WIDTH];
    assign token_length = head[LEN_WIDTH-1:0];

endmodule
